// File: hdl/projected_quad_occlusion_test_top_assert.svh
// Assertion macros shared by the projected quad occlusion test RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef PROJECTED_QUAD_OCCLUSION_TEST_TOP_ASSERT_SVH
`define PROJECTED_QUAD_OCCLUSION_TEST_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PQOT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PQOT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQOT_ASSERT(label, clk, rst, prop, msg)
`define PQOT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/pqot_pkg.sv
// Package for the projected quad occlusion test: widths, constants and types.
// Depends on nothing; used by every other file of the block but the assertion header.
package pqot_pkg;

  localparam int COORD_FRAC_BITS = 12;

  localparam int C_W     = 16;  // coordinate width
  localparam int DIFF_W  = 17;  // coordinate difference
  localparam int PROD_W  = 34;  // product of two differences
  localparam int SUM_W   = 36;  // area term and barycentric numerators
  localparam int TEST_W  = 54;  // numerator scaled by the edge tolerance
  localparam int NUM_W   = 54;  // depth numerator
  localparam int REM_W   = 52;  // divider remainder
  localparam int DV_W    = SUM_W - 1;  // positive divisor
  localparam int QB      = 18;  // quotient bits produced by the divider
  localparam int SAT_W   = 19;  // quotient plus corner depth before saturation
  localparam int CMP_W   = 18;  // depth comparison
  localparam int EPS_W   = 15;
  localparam int TOL_SHIFT = 16;
  localparam int LANE_ST = 5;   // register stages in a triangle lane

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 2;

  localparam longint AREA_EPS = (longint'(1) << (2 * COORD_FRAC_BITS)) / 1000000;

  typedef logic signed [C_W-1:0]    coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  localparam sum_t   AREA_EPS_S = sum_t'(AREA_EPS);
  localparam coord_t DEPTH_MAX  = coord_t'(16'h7FFF);
  localparam coord_t DEPTH_MIN  = coord_t'(16'h8000);

  localparam logic [PADDR_W-1:0] ADDR_DEPTH_EPS = PADDR_W'(0);

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } corner_t;

  // Result of one triangle lane, with the sign of the area already folded in.
  typedef struct packed {
    logic  ok;
    sum_t  d;
    sum_t  na;
    sum_t  nb;
    diff_t dza;
    diff_t dzb;
    coord_t cz;
  } lane_out_t;

  // Per-item data that rides along the divider.
  typedef struct packed {
    logic   in_quad;
    coord_t cz;
    coord_t pz;
  } side_t;

  typedef struct packed {
    logic          valid;
    logic          low;
    logic          high;
    logic [QB-1:0] q;
    side_t         side;
  } div_out_t;

endpackage

// File: hdl/pqot_channels.sv
// Stream interfaces of the projected quad occlusion test: query and result.
// Depends on pqot_pkg for the coordinate type.
interface pqot_query_if import pqot_pkg::*; ();
  logic        valid;
  logic        ready;
  coord_t      point_x;
  coord_t      point_y;
  coord_t      point_z;
  logic [47:0] corner_zero;
  logic [47:0] corner_one;
  logic [47:0] corner_two;
  logic [47:0] corner_three;

  modport source (
    output valid, point_x, point_y, point_z,
    output corner_zero, corner_one, corner_two, corner_three,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z,
    input  corner_zero, corner_one, corner_two, corner_three,
    output ready
  );
endinterface

interface pqot_result_if import pqot_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   behind;
  logic   inside_res;
  coord_t plane_depth;

  modport source (output valid, behind, inside_res, plane_depth, input ready);
  modport sink (input valid, behind, inside_res, plane_depth, output ready);
endinterface

// File: hdl/projected_quad_occlusion_test_top.sv
// Projected quad occlusion test: point against quad triangles with plane depth test.
// Throughput: one query transaction per cycle while the skid register is empty, set by
// the fully pipelined lanes and the divider: a range check, then one quotient bit per stage.
// Reset (rst, synchronous, active high) empties the pipeline and clears depth_epsilon.
`include "projected_quad_occlusion_test_top_assert.svh"

module projected_quad_occlusion_test_top import pqot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pqot_query_if.sink         query,
  pqot_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------------
  // Flow control. Every pipeline register moves together on adv. The output
  // side has a main register and a skid register: while the main result waits
  // for the sink, one more finished result may land in the skid register. Only
  // when the skid register is occupied does the whole pipeline freeze, so the
  // block keeps taking query transactions while a result waits to be taken.
  // ---------------------------------------------------------------------------
  logic adv;
  logic ov;  // main output register holds a result
  logic sv;  // skid register holds a result

  assign adv         = !sv;
  assign query.ready = adv;

  // ---------------------------------------------------------------------------
  // Configuration register. Writes complete in the APB access phase; pready
  // is tied high so every access finishes without wait states.
  // ---------------------------------------------------------------------------
  logic [EPS_W-1:0] eps;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DEPTH_EPS) ? PDATA_W'(eps) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_DEPTH_EPS)) begin
      eps <= pwdata[EPS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Triangle lanes. The quad splits into triangles (0,1,2) and (0,2,3); both
  // are evaluated in parallel and the first one that contains the point wins.
  // The point depth and the valid bit ride in a shift line alongside.
  // ---------------------------------------------------------------------------
  lane_out_t lane_a, lane_b;
  logic      vl    [0:LANE_ST-1];
  coord_t    pz_sl [0:LANE_ST-1];

  pqot_tri_lane u_lane_a (
    .clk (clk),
    .adv (adv),
    .px  (query.point_x),
    .py  (query.point_y),
    .ka  (corner_t'(query.corner_zero)),
    .kb  (corner_t'(query.corner_one)),
    .kc  (corner_t'(query.corner_two)),
    .lo  (lane_a)
  );

  pqot_tri_lane u_lane_b (
    .clk (clk),
    .adv (adv),
    .px  (query.point_x),
    .py  (query.point_y),
    .ka  (corner_t'(query.corner_zero)),
    .kb  (corner_t'(query.corner_two)),
    .kc  (corner_t'(query.corner_three)),
    .lo  (lane_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_ST; i++) begin
        vl[i] <= 1'b0;
      end
    end else if (adv) begin
      vl[0] <= query.valid;
      for (int i = 1; i < LANE_ST; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pz_sl[0] <= query.point_z;
      for (int i = 1; i < LANE_ST; i++) begin
        pz_sl[i] <= pz_sl[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Depth numerator. The chosen triangle's weights scale the corner depth
  // differences (one register after the multipliers), the two products are
  // summed, and the sum is offset by the divisor times 2^(QB-1) so that the
  // divider only ever sees a non-negative numerator for in-range quotients.
  // Adding a whole multiple of the divisor keeps the floor exact.
  // ---------------------------------------------------------------------------
  logic  t1_v, t2_v, t3_v, t4_v;
  sum_t  t1_na, t1_nb, t1_d, t2_d, t3_d, t4_d;
  diff_t t1_dza, t1_dzb;
  side_t t1_side, t2_side, t3_side, t4_side;
  num_t  t2_p1, t2_p2, t3_num, t4_numo;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
    end else if (adv) begin
      t1_v <= vl[LANE_ST-1];
      t2_v <= t1_v;
      t3_v <= t2_v;
      t4_v <= t3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Triangle (0,1,2) takes priority over (0,2,3).
      t1_na           <= lane_a.ok ? lane_a.na : lane_b.na;
      t1_nb           <= lane_a.ok ? lane_a.nb : lane_b.nb;
      t1_d            <= lane_a.ok ? lane_a.d : lane_b.d;
      t1_dza          <= lane_a.ok ? lane_a.dza : lane_b.dza;
      t1_dzb          <= lane_a.ok ? lane_a.dzb : lane_b.dzb;
      t1_side.cz      <= lane_a.ok ? lane_a.cz : lane_b.cz;
      t1_side.in_quad <= lane_a.ok || lane_b.ok;
      t1_side.pz      <= pz_sl[LANE_ST-1];

      t2_p1   <= NUM_W'(t1_na) * NUM_W'(t1_dza);
      t2_p2   <= NUM_W'(t1_nb) * NUM_W'(t1_dzb);
      t2_d    <= t1_d;
      t2_side <= t1_side;

      t3_num  <= t2_p1 + t2_p2;
      t3_d    <= t2_d;
      t3_side <= t2_side;

      t4_numo <= t3_num + (NUM_W'(t3_d) <<< (QB - 1));
      t4_d    <= t3_d;
      t4_side <= t3_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: floor(numo / d) as QB bits, or a flag that it is out of range.
  // ---------------------------------------------------------------------------
  div_out_t div_o;

  pqot_depth_div u_div (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .iv   (t4_v),
    .numo (t4_numo),
    .dv   (t4_d[DV_W-1:0]),
    .side (t4_side),
    .dout (div_o)
  );

  // ---------------------------------------------------------------------------
  // Final stage: remove the offset (flip the top quotient bit), add the depth
  // of corner c, saturate to the coordinate range. A point outside both
  // triangles reports zero depth.
  // ---------------------------------------------------------------------------
  logic signed [QB-1:0]    qoff;
  logic signed [SAT_W-1:0] qsum;
  coord_t                  qsat;
  logic                    f_valid, f_inside;
  coord_t                  f_depth, f_pz;

  assign qoff = {~div_o.q[QB-1], div_o.q[QB-2:0]};
  assign qsum = SAT_W'(qoff) + SAT_W'(div_o.side.cz);

  always_comb begin
    priority if (div_o.low) begin
      qsat = DEPTH_MIN;
    end else if (div_o.high) begin
      qsat = DEPTH_MAX;
    end else if (qsum > SAT_W'(DEPTH_MAX)) begin
      qsat = DEPTH_MAX;
    end else if (qsum < SAT_W'(DEPTH_MIN)) begin
      qsat = DEPTH_MIN;
    end else begin
      qsat = qsum[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= div_o.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_inside <= div_o.side.in_quad;
      f_depth  <= div_o.side.in_quad ? qsat : coord_t'(0);
      f_pz     <= div_o.side.pz;
    end
  end

  // The point is behind when it is inside and not nearer than the plane
  // depth minus the tolerance. The comparison is done wide enough not to wrap.
  logic signed [CMP_W-1:0] depth_lim;
  logic                    f_behind;

  assign depth_lim = CMP_W'(f_depth) - CMP_W'($signed({1'b0, eps}));
  assign f_behind  = f_inside && (CMP_W'(f_pz) >= depth_lim);

  // ---------------------------------------------------------------------------
  // Output register with skid register.
  // ---------------------------------------------------------------------------
  logic   main_behind, main_inside, skid_behind, skid_inside;
  coord_t main_depth, skid_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (result.ready) begin
        sv <= 1'b0;
      end
    end else if (ov && !result.ready) begin
      sv <= f_valid;
    end else begin
      ov <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (result.ready) begin
        main_behind <= skid_behind;
        main_inside <= skid_inside;
        main_depth  <= skid_depth;
      end
    end else if (ov && !result.ready) begin
      skid_behind <= f_behind;
      skid_inside <= f_inside;
      skid_depth  <= f_depth;
    end else begin
      main_behind <= f_behind;
      main_inside <= f_inside;
      main_depth  <= f_depth;
    end
  end

  assign result.valid       = ov;
  assign result.behind      = main_behind;
  assign result.inside_res  = main_inside;
  assign result.plane_depth = main_depth;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  logic res_outside, res_cleared;

  assign res_outside = result.valid && !result.inside_res;
  assign res_cleared = (result.plane_depth == coord_t'(0)) && !result.behind;

  `PQOT_ASSERT(a_skid_after_main, clk, rst, sv |-> ov, "skid register filled while output empty")
  `PQOT_ASSERT(a_freeze_holds, clk, rst, sv |=> $stable(f_valid), "pipeline moved while frozen")
  `PQOT_ASSERT(a_div_range, clk, rst, div_o.valid |-> !(div_o.low && div_o.high), "flags clash")
  `PQOT_ASSERT(a_outside_zero, clk, rst, res_outside |-> res_cleared, "outside point not cleared")
  `PQOT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!result.valid && !sv), "busy after reset")

endmodule

// File: hdl/pqot_tri_lane.sv
// One triangle lane: barycentric numerators, area rejection and edge test.
// Depends on pqot_pkg; five register stages, all moved by adv.
module pqot_tri_lane import pqot_pkg::*; (
  input  logic      clk,
  input  logic      adv,
  input  coord_t    px,
  input  coord_t    py,
  input  corner_t   ka,
  input  corner_t   kb,
  input  corner_t   kc,
  output lane_out_t lo
);

  // True when weight n/d lies below the negative edge tolerance (d > 0).
  function automatic logic below_tol(input sum_t n, input sum_t d);
    logic signed [TEST_W-1:0] t;
    t = (TEST_W'(n) <<< TOL_SHIFT) + TEST_W'(d);
    return t[TEST_W-1];
  endfunction

  diff_t  bcy, cbx, acx, acy, cay, pcx, pcy;
  diff_t  dza [1:4];
  diff_t  dzb [1:4];
  coord_t cz  [1:4];
  prod_t  m_d1, m_d2, m_a1, m_a2, m_b1, m_b2;
  sum_t   d3, na3, nb3;
  sum_t   d4, na4, nb4, nc4;
  logic   degen4;
  logic   d3_neg, d3_small;

  assign d3_neg   = d3[SUM_W-1];
  assign d3_small = (d3 <= AREA_EPS_S) && (d3 >= -AREA_EPS_S);

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: edge vectors relative to corner c.
      bcy    <= DIFF_W'(kb.y) - DIFF_W'(kc.y);
      cbx    <= DIFF_W'(kc.x) - DIFF_W'(kb.x);
      acx    <= DIFF_W'(ka.x) - DIFF_W'(kc.x);
      acy    <= DIFF_W'(ka.y) - DIFF_W'(kc.y);
      cay    <= DIFF_W'(kc.y) - DIFF_W'(ka.y);
      pcx    <= DIFF_W'(px) - DIFF_W'(kc.x);
      pcy    <= DIFF_W'(py) - DIFF_W'(kc.y);
      dza[1] <= DIFF_W'(ka.z) - DIFF_W'(kc.z);
      dzb[1] <= DIFF_W'(kb.z) - DIFF_W'(kc.z);
      cz[1]  <= kc.z;
      // Stage 2: cross products.
      m_d1   <= PROD_W'(bcy) * PROD_W'(acx);
      m_d2   <= PROD_W'(cbx) * PROD_W'(acy);
      m_a1   <= PROD_W'(bcy) * PROD_W'(pcx);
      m_a2   <= PROD_W'(cbx) * PROD_W'(pcy);
      m_b1   <= PROD_W'(cay) * PROD_W'(pcx);
      m_b2   <= PROD_W'(acx) * PROD_W'(pcy);
      dza[2] <= dza[1];
      dzb[2] <= dzb[1];
      cz[2]  <= cz[1];
      // Stage 3: area term and the first two weight numerators.
      d3     <= SUM_W'(m_d1) + SUM_W'(m_d2);
      na3    <= SUM_W'(m_a1) + SUM_W'(m_a2);
      nb3    <= SUM_W'(m_b1) + SUM_W'(m_b2);
      dza[3] <= dza[2];
      dzb[3] <= dzb[2];
      cz[3]  <= cz[2];
      // Stage 4: third numerator, and flip all signs so the area is positive.
      d4     <= d3_neg ? -d3 : d3;
      na4    <= d3_neg ? -na3 : na3;
      nb4    <= d3_neg ? -nb3 : nb3;
      nc4    <= d3_neg ? (na3 + nb3 - d3) : (d3 - na3 - nb3);
      degen4 <= d3_small;
      dza[4] <= dza[3];
      dzb[4] <= dzb[3];
      cz[4]  <= cz[3];
      // Stage 5: edge tolerance test.
      lo.ok  <= !degen4 && !below_tol(na4, d4) && !below_tol(nb4, d4) &&
                !below_tol(nc4, d4);
      lo.d   <= d4;
      lo.na  <= na4;
      lo.nb  <= nb4;
      lo.dza <= dza[4];
      lo.dzb <= dzb[4];
      lo.cz  <= cz[4];
    end
  end

endmodule

// File: hdl/pqot_depth_div.sv
// Restoring divider for the plane depth: range check, then one quotient bit per stage.
// Depends on pqot_pkg; QB + 1 register stages, all moved by adv.
module pqot_depth_div import pqot_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            iv,
  input  num_t            numo,
  input  logic [DV_W-1:0] dv,
  input  side_t           side,
  output div_out_t        dout
);

  logic            vs     [0:QB];
  logic            low_s  [0:QB];
  logic            high_s [0:QB];
  side_t           side_s [0:QB];
  logic [REM_W-1:0] rem_s [0:QB-1];
  logic [DV_W-1:0] dv_s   [0:QB-1];
  logic [QB-1:0]   q_s    [1:QB];

  // Stage 0: a negative offset numerator saturates low, one at or above
  // the divisor times 2^QB saturates high; otherwise the quotient fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (adv) begin
      vs[0] <= iv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      low_s[0]  <= numo[NUM_W-1];
      high_s[0] <= !numo[NUM_W-1] && (numo[REM_W-1:0] >= (REM_W'(dv) << QB));
      rem_s[0]  <= numo[REM_W-1:0];
      dv_s[0]   <= dv;
      side_s[0] <= side;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [REM_W-1:0] sub;
    logic             ge;

    assign sub = REM_W'(dv_s[k-1]) << (QB - k);
    assign ge  = rem_s[k-1] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (adv) begin
        vs[k] <= vs[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        low_s[k]  <= low_s[k-1];
        high_s[k] <= high_s[k-1];
        side_s[k] <= side_s[k-1];
      end
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          q_s[k] <= QB'(ge);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          q_s[k] <= {q_s[k-1][QB-2:0], ge};
        end
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[k] <= ge ? (rem_s[k-1] - sub) : rem_s[k-1];
          dv_s[k]  <= dv_s[k-1];
        end
      end
    end
  end

  assign dout.valid = vs[QB];
  assign dout.low   = low_s[QB];
  assign dout.high  = high_s[QB];
  assign dout.q     = q_s[QB];
  assign dout.side  = side_s[QB];

endmodule
